// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen on a rising clock outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/btpc_pkg.sv -----
// Types, constants and multiply helpers for the compensation core.
// No dependencies.
package btpc_pkg;

	localparam int unsigned NUM_REGS   = 6;
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned DIV_STAGES = 64;

	localparam logic [2:0] REG_CAL_T1_T2 = 3'd0;
	localparam logic [2:0] REG_CAL_T3_P1 = 3'd1;
	localparam logic [2:0] REG_CAL_P2_P3 = 3'd2;
	localparam logic [2:0] REG_CAL_P4_P5 = 3'd3;
	localparam logic [2:0] REG_CAL_P6_P7 = 3'd4;
	localparam logic [2:0] REG_CAL_P8_P9 = 3'd5;

	localparam logic signed [24:0] T_FINE_OFFSET = 25'sd128000;
	localparam logic [20:0]        P_BASE        = 21'd1048576;
	localparam logic [63:0]        P_SCALE       = 64'd3125;
	localparam logic [63:0]        V1_BIAS       = 64'h0000_8000_0000_0000;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] temperature_centideg;
		logic signed [31:0] fine_temperature;
		logic [31:0]        pressure_q24_8;
		logic               pressure_valid;
	} out_word_t;

	// temperature results that ride along the pressure pipeline
	typedef struct packed {
		logic signed [31:0] fine;
		logic signed [15:0] tc;
	} side_t;

	// partial products of a 64x64 multiply kept modulo 2^64
	typedef struct packed {
		logic [63:0] ll;
		logic [31:0] lh;
		logic [31:0] hl;
	} mul_part_t;

	function automatic mul_part_t mul_part(input logic [63:0] a, input logic [63:0] b);
		mul_part_t r;
		r.ll = 64'(a[31:0]) * 64'(b[31:0]);
		r.lh = a[31:0] * b[63:32];
		r.hl = a[63:32] * b[31:0];
		return r;
	endfunction

	function automatic logic [63:0] mul_join(input mul_part_t p);
		logic [31:0] mid;
		mid = p.lh + p.hl;
		return p.ll + {mid, 32'd0};
	endfunction

endpackage

// ----- hw/rtl/baro_temp_press_compensation_core.sv -----
// Barometric temperature/pressure compensation core, 64-bit integer scheme.
// One word accepted every cycle, busy stays low.
// Depth set by 14 front stages (multiplies), a 64-stage one-bit-per-stage divider
// and 7 back stages. done pulses one cycle; the receiver cannot stall.
// Reset clears the valid bits and the calibration registers.
// Uses btpc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module baro_temp_press_compensation_core
	import btpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  in_word_t            operands,
	output logic                done,
	output out_word_t           result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int unsigned LATENCY = 14 + DIV_STAGES + 7;

	// ---------------- configuration ----------------
	logic [31:0] cal_q [NUM_REGS];
	logic [2:0]  reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cal_q[i] <= '0;
		end else if (psel && penable && pwrite && pready && (32'(reg_idx) < NUM_REGS)) begin
			cal_q[reg_idx] <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (32'(reg_idx) < NUM_REGS) prdata = cal_q[reg_idx];
	end

	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = cal_q[REG_CAL_T1_T2][15:0];
	assign t2 = $signed(cal_q[REG_CAL_T1_T2][31:16]);
	assign t3 = $signed(cal_q[REG_CAL_T3_P1][15:0]);
	assign p1 = cal_q[REG_CAL_T3_P1][31:16];
	assign p2 = $signed(cal_q[REG_CAL_P2_P3][15:0]);
	assign p3 = $signed(cal_q[REG_CAL_P2_P3][31:16]);
	assign p4 = $signed(cal_q[REG_CAL_P4_P5][15:0]);
	assign p5 = $signed(cal_q[REG_CAL_P4_P5][31:16]);
	assign p6 = $signed(cal_q[REG_CAL_P6_P7][15:0]);
	assign p7 = $signed(cal_q[REG_CAL_P6_P7][31:16]);
	assign p8 = $signed(cal_q[REG_CAL_P8_P9][15:0]);
	assign p9 = $signed(cal_q[REG_CAL_P8_P9][31:16]);

	assign busy = 1'b0;

	// ---------------- valid chain ----------------
	logic [21:1] v_s;
	logic [DIV_STAGES-1:0] div_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s     <= '0;
			div_v_s <= '0;
		end else begin
			v_s[1]  <= start && !busy;
			for (int i = 2; i <= 14; i++) v_s[i] <= v_s[i-1];
			div_v_s <= {div_v_s[DIV_STAGES-2:0], v_s[14]};
			v_s[15] <= div_v_s[DIV_STAGES-1];
			for (int i = 16; i <= 21; i++) v_s[i] <= v_s[i-1];
		end
	end

	// ---------------- temperature path ----------------
	logic signed [17:0] tx_s1, td_s1;
	logic [20:0]        pd_s1, pd_s2, pd_s3, pd_s4, pd_s5, pd_s6, pd_s7, pd_s8, pd_s9, pd_s10;
	logic signed [33:0] tp_s2;
	logic signed [35:0] dd_s2;
	logic signed [22:0] at_s3, at_s4;
	logic signed [23:0] ddsh_s3;
	logic signed [39:0] btp_s4;
	logic signed [31:0] fine_s5;

	always_ff @(posedge clk) begin
		tx_s1  <= $signed({1'b0, operands.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
		td_s1  <= $signed({2'b0, operands.raw_temperature[19:4]}) - $signed({2'b0, t1});
		pd_s1  <= P_BASE - 21'(operands.raw_pressure);
		tp_s2  <= tx_s1 * t2;
		dd_s2  <= td_s1 * td_s1;
		pd_s2  <= pd_s1;
		at_s3  <= 23'(tp_s2 >>> 11);
		ddsh_s3 <= dd_s2[35:12];
		pd_s3  <= pd_s2;
		btp_s4 <= ddsh_s3 * t3;
		at_s4  <= at_s3;
		pd_s4  <= pd_s3;
		fine_s5 <= 32'(at_s4) + 32'(btp_s4 >>> 14);
		pd_s5  <= pd_s4;
	end

	// ---------------- centidegrees and pressure front end ----------------
	logic signed [35:0] t5, tsh;
	logic signed [15:0] tc_c;

	always_comb begin
		t5  = 36'(fine_s5) * 36'sd5 + 36'sd128;
		tsh = t5 >>> 8;
		if (tsh > 36'sd32767)       tc_c = 16'sd32767;
		else if (tsh < -36'sd32768) tc_c = -16'sd32768;
		else                        tc_c = 16'(tsh);
	end

	side_t side_s6, side_s7, side_s8, side_s9, side_s10, side_s11, side_s12, side_s13;
	logic signed [24:0] pa_s6;
	logic signed [49:0] aa_s7;
	logic signed [40:0] ap5_s7, ap2_s7, ap5_s8, ap2_s8, ap5_s9, ap2_s9;
	mul_part_t          mb1_s8, ma3_s8;
	logic signed [63:0] b1_s9, a3_s9, bsum_s10, a2_s10, num0_s11, v1_s12, num_s13;
	mul_part_t          mv1_s11, mn_s12;
	logic signed [30:0] var1_s13;

	always_ff @(posedge clk) begin
		side_s6.fine <= fine_s5;
		side_s6.tc   <= tc_c;
		pa_s6        <= 25'(fine_s5) - T_FINE_OFFSET;
		pd_s6        <= pd_s5;

		aa_s7  <= pa_s6 * pa_s6;
		ap5_s7 <= pa_s6 * p5;
		ap2_s7 <= pa_s6 * p2;
		side_s7 <= side_s6;
		pd_s7  <= pd_s6;

		mb1_s8 <= mul_part(64'(aa_s7), 64'(p6));
		ma3_s8 <= mul_part(64'(aa_s7), 64'(p3));
		ap5_s8 <= ap5_s7;
		ap2_s8 <= ap2_s7;
		side_s8 <= side_s7;
		pd_s8  <= pd_s7;

		b1_s9  <= $signed(mul_join(mb1_s8));
		a3_s9  <= $signed(mul_join(ma3_s8));
		ap5_s9 <= ap5_s8;
		ap2_s9 <= ap2_s8;
		side_s9 <= side_s8;
		pd_s9  <= pd_s8;

		bsum_s10 <= b1_s9 + (64'(ap5_s9) <<< 17) + (64'(p4) <<< 35);
		a2_s10   <= (a3_s9 >>> 8) + (64'(ap2_s9) <<< 12);
		side_s10 <= side_s9;
		pd_s10   <= pd_s9;

		mv1_s11  <= mul_part(V1_BIAS + a2_s10, 64'(p1));
		num0_s11 <= $signed(64'(pd_s10) << 31) - bsum_s10;
		side_s11 <= side_s10;

		v1_s12   <= $signed(mul_join(mv1_s11));
		mn_s12   <= mul_part(num0_s11, P_SCALE);
		side_s12 <= side_s11;

		var1_s13 <= v1_s12[63:33];
		num_s13  <= $signed(mul_join(mn_s12));
		side_s13 <= side_s12;
	end

	// ---------------- signed division, one quotient bit per stage ----------------
	logic [30:0] div_rem_s [0:DIV_STAGES];
	logic [63:0] div_nq_s  [0:DIV_STAGES];
	logic [30:0] div_d_s   [0:DIV_STAGES];
	logic        div_neg_s [0:DIV_STAGES];
	logic        div_dz_s  [0:DIV_STAGES];
	side_t       div_side_s [0:DIV_STAGES];

	always_ff @(posedge clk) begin
		div_rem_s[0]  <= '0;
		div_nq_s[0]   <= num_s13[63] ? (64'd0 - num_s13) : num_s13;
		div_d_s[0]    <= var1_s13[30] ? (31'd0 - var1_s13) : var1_s13;
		div_neg_s[0]  <= num_s13[63] ^ var1_s13[30];
		div_dz_s[0]   <= (var1_s13 == '0);
		div_side_s[0] <= side_s13;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [31:0] trial;
		logic        ge;

		assign trial = {div_rem_s[k], div_nq_s[k][63]};
		assign ge    = trial >= {1'b0, div_d_s[k]};

		always_ff @(posedge clk) begin
			div_rem_s[k+1]  <= ge ? 31'(trial - {1'b0, div_d_s[k]}) : trial[30:0];
			div_nq_s[k+1]   <= {div_nq_s[k][62:0], ge};
			div_d_s[k+1]    <= div_d_s[k];
			div_neg_s[k+1]  <= div_neg_s[k];
			div_dz_s[k+1]   <= div_dz_s[k];
			div_side_s[k+1] <= div_side_s[k];
		end
	end

	// ---------------- pressure back end ----------------
	logic signed [63:0] q_s15, q_s16, q_s17, q_s18, q_s19;
	logic               dz_s15, dz_s16, dz_s17, dz_s18, dz_s19, dz_s20;
	side_t              side_s15, side_s16, side_s17, side_s18, side_s19, side_s20;
	mul_part_t          mp9_s16, mp8_s16, mp2_s18;
	logic signed [63:0] m1_s17, m3_s17, m3_s18, m3_s19, m2_s19, sum_s20;
	out_word_t          res_s21;

	always_ff @(posedge clk) begin
		q_s15    <= div_neg_s[DIV_STAGES] ? $signed(64'd0 - div_nq_s[DIV_STAGES])
		                                  : $signed(div_nq_s[DIV_STAGES]);
		dz_s15   <= div_dz_s[DIV_STAGES];
		side_s15 <= div_side_s[DIV_STAGES];

		mp9_s16  <= mul_part(64'(p9), q_s15 >>> 13);
		mp8_s16  <= mul_part(64'(p8), q_s15);
		q_s16    <= q_s15;
		dz_s16   <= dz_s15;
		side_s16 <= side_s15;

		m1_s17   <= $signed(mul_join(mp9_s16));
		m3_s17   <= $signed(mul_join(mp8_s16));
		q_s17    <= q_s16;
		dz_s17   <= dz_s16;
		side_s17 <= side_s16;

		mp2_s18  <= mul_part(m1_s17, q_s17 >>> 13);
		m3_s18   <= m3_s17;
		q_s18    <= q_s17;
		dz_s18   <= dz_s17;
		side_s18 <= side_s17;

		m2_s19   <= $signed(mul_join(mp2_s18));
		m3_s19   <= m3_s18;
		q_s19    <= q_s18;
		dz_s19   <= dz_s18;
		side_s19 <= side_s18;

		sum_s20  <= q_s19 + (m2_s19 >>> 25) + (m3_s19 >>> 19);
		dz_s20   <= dz_s19;
		side_s20 <= side_s19;
	end

	logic signed [63:0] fp_c;
	logic [31:0]        press_c;

	always_comb begin
		fp_c = (sum_s20 >>> 8) + (64'(p7) <<< 4);
		if (dz_s20)            press_c = '0;
		else if (fp_c[63])     press_c = '0;   // negative pressure clamps to zero
		else if (|fp_c[62:32]) press_c = '1;
		else                   press_c = fp_c[31:0];
	end

	always_ff @(posedge clk) begin
		res_s21.temperature_centideg <= side_s20.tc;
		res_s21.fine_temperature     <= side_s20.fine;
		res_s21.pressure_q24_8       <= press_c;
		res_s21.pressure_valid       <= !dz_s20;
	end

	assign done   = v_s[21];
	assign result = res_s21;

	// ---------------- checks ----------------
	`ASSERT_CLK(a_fixed_latency, start && !busy |-> ##LATENCY done, "word lost in pipeline")
	`ASSERT_CLK(a_invalid_zero, done && !result.pressure_valid |-> result.pressure_q24_8 == 0, "invalid pressure not zero")
	`ASSERT_CLK(a_div_flow, div_v_s[DIV_STAGES-1] |=> v_s[15], "divider output dropped")
	`ASSERT_NEVER(a_never_busy, busy, "busy raised")

endmodule
